// ----- design/wlt_pkg.sv -----
// ----------------------------------------------------------------------------
// wlt_pkg
// Shared types, codes and constants of the windowed latency tracker.
// ----------------------------------------------------------------------------
package wlt_pkg;

    localparam int DEF_NUM_DEVICES  = 8;
    localparam int DEF_WINDOW_DEPTH = 100;
    localparam int DEF_LATENCY_BITS = 24;

    localparam int DEV_IDX_W  = 3;
    localparam int MASK_W     = 8;
    localparam int THR_W      = 8;
    localparam int COUNT_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int COMP_MIN_COUNT    = 5;
    localparam int OUTLIER_MIN_COUNT = 10;

    // 3.0 sigma in Q4.4
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd48;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DEVICE_MASK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTLIER_EN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_OUTLIER  = 2'd1,
        ST_DISABLED = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_CHECK, S_DEV1, S_DEV2, S_DEV3, S_RHS1, S_RHS2, S_CMP,
        S_SQR, S_UPD, S_MGO, S_MWAIT, S_VGO, S_VWAIT, S_QGO, S_QWAIT, S_FIN,
        S_WB, S_OUT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    load;
        logic    dev1;
        logic    dev2;
        logic    dev3;
        logic    rhs1;
        logic    rhs2;
        logic    sqr;
        logic    upd;
        logic    div_start;
        logic    sel_var;
        logic    take_mean;
        logic    sqrt_start;
        logic    fin;
        logic    wb;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic check_needed;
        logic outlier;
        logic div_done;
        logic sqrt_done;
        logic out_busy;
    } sts_t;

    function automatic int byte_pad(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ----- design/windowed_latency_tracker_core.sv -----
// Steps: a disabled slot goes through load and check to the result register; an
//   outlier adds the deviation sum, threshold product and compare. An accepted
//   sample adds squares, update, mean and variance divisions, root and write-back.
// One word at a time: the next is taken once the previous result is loaded.
// Reset: synchronous, active low; slots cleared, mask 0, outlier test on, threshold
//   3.0 sigma. Window memory is not cleared; unwritten entries are never used.
// ----------------------------------------------------------------------------
// windowed_latency_tracker_core
// Per-slot sliding window latency statistics with sigma outlier rejection.
// ----------------------------------------------------------------------------
module windowed_latency_tracker_core #(
    parameter int NUM_DEVICES  = wlt_pkg::DEF_NUM_DEVICES,
    parameter int WINDOW_DEPTH = wlt_pkg::DEF_WINDOW_DEPTH,
    parameter int LATENCY_BITS = wlt_pkg::DEF_LATENCY_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes, to be made only while idle; the block does not enforce this
    input  logic                                  cfg_wr_en,
    input  logic [wlt_pkg::CFG_ADDR_W-1:0]        cfg_index,
    input  logic [wlt_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // sample words
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields from bit 0: device_index, latency
    input  logic [wlt_pkg::byte_pad(LATENCY_BITS+3)-1:0] s_axis_tdata,
    // result words
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // fields from bit 0: status, device_slot, mean_latency, minimum,
    // maximum, jitter, compensation, sample_total
    output logic [wlt_pkg::byte_pad(5*LATENCY_BITS+38)-1:0] m_axis_tdata
);
    import wlt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: one word in flight; the result register lets the next
    // word in while a result still waits downstream
    wlt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // datapath: stats table, window memory, divider, square root
    wlt_dp #(
        .NUM_DEVICES  (NUM_DEVICES),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .LATENCY_BITS (LATENCY_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_slot       (s_axis_tdata[DEV_IDX_W-1:0]),
        .in_latency    (s_axis_tdata[DEV_IDX_W+LATENCY_BITS-1:DEV_IDX_W]),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- design/wlt_div.sv -----
// ----------------------------------------------------------------------------
// wlt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlt_div #(
    parameter int DVD_W = 55,
    parameter int DVS_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end else if (run_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            if (fits) begin
                rem_reg <= DVS_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[DVS_W-1:0];
            end
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/wlt_sqrt.sv -----
// ----------------------------------------------------------------------------
// wlt_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wlt_sqrt #(
    parameter int W = 55
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [W-1:0]         operand,
    output logic                 done,
    output logic [(W+1)/2-1:0]   root
);
    localparam int ITER   = (W + 1) / 2;
    localparam int RW     = 2 * ITER;
    localparam int STEP_W = $clog2(ITER + 1);

    logic [RW-1:0]     v_reg;
    logic [RW-1:0]     res_reg;
    logic [RW-1:0]     bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [RW:0]       trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(ITER);
            end else if (run_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= RW'(operand);
            res_reg <= '0;
            bit_reg <= RW'(1) << (RW - 2);
        end else if (run_reg) begin
            if ({1'b0, v_reg} >= trial) begin
                v_reg   <= RW'({1'b0, v_reg} - trial);
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ITER-1:0];

endmodule

// ----- design/wlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// wlt_ctrl
// Sequencer: steps one sample through check, update and statistics.
// ----------------------------------------------------------------------------
module wlt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  wlt_pkg::sts_t sts,
    output wlt_pkg::cmd_t cmd
);
    import wlt_pkg::*;

    state_t  state_reg, state_next;
    logic    phase_reg, phase_next;   // 0: outlier check, 1: statistics update
    status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            phase_reg  <= 1'b0;
            status_reg <= ST_ACCEPTED;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_LOAD;
            S_LOAD:  state_next = S_CHECK;
            S_CHECK: begin
                if (!sts.enabled) begin
                    status_next = ST_DISABLED;
                    state_next  = S_OUT;
                end else if (sts.check_needed) begin
                    phase_next = 1'b0;
                    state_next = S_DEV1;
                end else begin
                    state_next = S_SQR;
                end
            end
            S_DEV1:  state_next = S_DEV2;
            S_DEV2:  state_next = S_DEV3;
            S_DEV3:  state_next = phase_reg ? S_VGO : S_RHS1;
            S_RHS1:  state_next = S_RHS2;
            S_RHS2:  state_next = S_CMP;
            S_CMP: begin
                if (sts.outlier) begin
                    status_next = ST_OUTLIER;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_SQR;
                end
            end
            S_SQR:   state_next = S_UPD;
            S_UPD:   state_next = S_MGO;
            S_MGO:   state_next = S_MWAIT;
            S_MWAIT: begin
                if (sts.div_done) begin
                    phase_next = 1'b1;
                    state_next = S_DEV1;
                end
            end
            S_VGO:   state_next = S_VWAIT;
            S_VWAIT: if (sts.div_done) state_next = S_QGO;
            S_QGO:   state_next = S_QWAIT;
            S_QWAIT: if (sts.sqrt_done) state_next = S_FIN;
            S_FIN:   state_next = S_WB;
            S_WB: begin
                status_next = ST_ACCEPTED;
                state_next  = S_OUT;
            end
            S_OUT:   if (!sts.out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.out_status = status_reg;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
            end
            S_LOAD:  cmd.load = 1'b1;
            S_DEV1:  cmd.dev1 = 1'b1;
            S_DEV2:  cmd.dev2 = 1'b1;
            S_DEV3:  cmd.dev3 = 1'b1;
            S_RHS1:  cmd.rhs1 = 1'b1;
            S_RHS2:  cmd.rhs2 = 1'b1;
            S_SQR:   cmd.sqr  = 1'b1;
            S_UPD:   cmd.upd  = 1'b1;
            S_MGO:   cmd.div_start = 1'b1;
            S_MWAIT: cmd.take_mean = sts.div_done;
            S_VGO: begin
                cmd.div_start = 1'b1;
                cmd.sel_var   = 1'b1;
            end
            S_QGO:   cmd.sqrt_start = 1'b1;
            S_FIN:   cmd.fin = 1'b1;
            S_WB:    cmd.wb  = 1'b1;
            S_OUT:   cmd.out_load = !sts.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- design/wlt_dp.sv -----
// ----------------------------------------------------------------------------
// wlt_dp
// Datapath: configuration, per-slot statistics, sample window memory,
// outlier test arithmetic, divider, square root and result register.
// ----------------------------------------------------------------------------
module wlt_dp #(
    parameter int NUM_DEVICES  = wlt_pkg::DEF_NUM_DEVICES,
    parameter int WINDOW_DEPTH = wlt_pkg::DEF_WINDOW_DEPTH,
    parameter int LATENCY_BITS = wlt_pkg::DEF_LATENCY_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [wlt_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [wlt_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [wlt_pkg::DEV_IDX_W-1:0]        in_slot,
    input  logic [LATENCY_BITS-1:0]              in_latency,
    input  wlt_pkg::cmd_t                        cmd,
    output wlt_pkg::sts_t                        sts,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [wlt_pkg::byte_pad(5*LATENCY_BITS+38)-1:0] m_axis_tdata
);
    import wlt_pkg::*;

    localparam int L      = LATENCY_BITS;
    localparam int DW     = 2 * L;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int WP_W   = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = L + CNT_W;
    localparam int SQ_W   = 2 * L + CNT_W;
    localparam int SLOT_W = $clog2(NUM_DEVICES);
    localparam int DEPTH  = NUM_DEVICES * WINDOW_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TT_W   = 2 * THR_W;
    localparam int HI_W   = SQ_W - 32;
    localparam int RLO_W  = TT_W + 32;
    localparam int RHI_W  = TT_W + HI_W;
    localparam int CMP_W  = SQ_W + TT_W;
    localparam int EXT_W  = SLOT_W + DEV_IDX_W;
    localparam int OUT_W  = byte_pad(5 * L + 38);
    localparam int ROOT_W = (SQ_W + 1) / 2;

    // configuration
    logic [MASK_W-1:0] mask_reg;
    logic              oen_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [MASK_W-1:0] rising;
    logic [NUM_DEVICES-1:0] clr_vec;

    // per-slot statistics
    logic [WP_W-1:0]    wp_arr_reg   [NUM_DEVICES];
    logic [CNT_W-1:0]   n_arr_reg    [NUM_DEVICES];
    logic [SUM_W-1:0]   rs_arr_reg   [NUM_DEVICES];
    logic [SQ_W-1:0]    rss_arr_reg  [NUM_DEVICES];
    logic [COUNT_W-1:0] cnt_arr_reg  [NUM_DEVICES];
    logic [L-1:0]       mn_arr_reg   [NUM_DEVICES];
    logic [L-1:0]       mx_arr_reg   [NUM_DEVICES];
    logic [L-1:0]       m_arr_reg    [NUM_DEVICES];
    logic [L-1:0]       sig_arr_reg  [NUM_DEVICES];
    logic [L:0]         comp_arr_reg [NUM_DEVICES];

    // sample window
    logic [L-1:0]      win_mem [DEPTH];
    logic [L-1:0]      mem_rd_reg;
    logic [ADDR_W-1:0] addr_reg;

    // working copy of the addressed slot
    logic [DEV_IDX_W-1:0] slot_reg;
    logic [L-1:0]         x_reg;
    logic [SLOT_W-1:0]    sidx_reg;
    logic                 en_reg;
    logic [WP_W-1:0]      wp_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [SUM_W-1:0]     rs_reg;
    logic [SQ_W-1:0]      rss_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [L-1:0]         mn_reg;
    logic [L-1:0]         mx_reg;
    logic [L-1:0]         m_reg;
    logic [L-1:0]         sig_reg;
    logic [L:0]           comp_reg;

    // arithmetic pipeline
    logic [DW-1:0]    dd_reg;
    logic [TT_W-1:0]  tt_reg;
    logic [DW-1:0]    mm_reg;
    logic [SQ_W-1:0]  mrs_reg;
    logic [SQ_W-1:0]  nmm_reg;
    logic [SQ_W-1:0]  lhs_reg;
    logic [SQ_W-1:0]  dsq_reg;
    logic [RLO_W-1:0] rlo_reg;
    logic [RHI_W-1:0] rhi_reg;
    logic [CMP_W-1:0] rhs_reg;
    logic [L-1:0]     old_reg;
    logic [DW-1:0]    osq_reg;
    logic [DW-1:0]    xsq_reg;

    logic [EXT_W-1:0]  slot_ext;
    logic [L-1:0]      abs_dev;
    logic              full;
    logic [L-1:0]      old_eff;
    logic [SQ_W-1:0]   div_q;
    logic              div_done;
    logic [ROOT_W-1:0] root;
    logic              sqrt_done;
    logic [SQ_W-1:0]   dvd;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    assign rising   = cfg_wdata & ~mask_reg;
    assign slot_ext = EXT_W'(in_slot);
    assign abs_dev  = (x_reg > m_reg) ? x_reg - m_reg : m_reg - x_reg;
    assign full     = n_reg >= CNT_W'(WINDOW_DEPTH);
    assign old_eff  = full ? mem_rd_reg : '0;
    assign dvd      = cmd.sel_var ? dsq_reg : SQ_W'(rs_reg);

    always_comb begin
        for (int i = 0; i < NUM_DEVICES; i++) begin
            clr_vec[i] = (i < MASK_W) ? rising[i % MASK_W] : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            oen_reg  <= 1'b1;
            thr_reg  <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEVICE_MASK: mask_reg <= cfg_wdata[MASK_W-1:0];
                CFG_OUTLIER_EN:  oen_reg  <= cfg_wdata[0];
                CFG_THRESHOLD:   thr_reg  <= cfg_wdata[THR_W-1:0];
                default:         mask_reg <= mask_reg;
            endcase
        end
    end

    // slot table: reset, clear on newly enabled slot, write-back of an update
    always_ff @(posedge aclk) begin
        for (int s = 0; s < NUM_DEVICES; s++) begin
            if (!aresetn || (cfg_wr_en && cfg_index == CFG_DEVICE_MASK && clr_vec[s])) begin
                wp_arr_reg[s]   <= '0;
                n_arr_reg[s]    <= '0;
                rs_arr_reg[s]   <= '0;
                rss_arr_reg[s]  <= '0;
                cnt_arr_reg[s]  <= '0;
                mn_arr_reg[s]   <= '1;
                mx_arr_reg[s]   <= '0;
                m_arr_reg[s]    <= '0;
                sig_arr_reg[s]  <= '0;
                comp_arr_reg[s] <= '0;
            end else if (cmd.wb && sidx_reg == SLOT_W'(s)) begin
                wp_arr_reg[s]   <= wp_reg;
                n_arr_reg[s]    <= n_reg;
                rs_arr_reg[s]   <= rs_reg;
                rss_arr_reg[s]  <= rss_reg;
                cnt_arr_reg[s]  <= cnt_reg;
                mn_arr_reg[s]   <= mn_reg;
                mx_arr_reg[s]   <= mx_reg;
                m_arr_reg[s]    <= m_reg;
                sig_arr_reg[s]  <= sig_reg;
                comp_arr_reg[s] <= comp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            win_mem[addr_reg] <= x_reg;
        end
        mem_rd_reg <= win_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            slot_reg <= in_slot;
            x_reg    <= in_latency;
            sidx_reg <= slot_ext[SLOT_W-1:0];
            en_reg   <= (slot_ext < EXT_W'(NUM_DEVICES)) && mask_reg[in_slot];
        end
        if (cmd.load) begin
            wp_reg   <= wp_arr_reg[sidx_reg];
            n_reg    <= n_arr_reg[sidx_reg];
            rs_reg   <= rs_arr_reg[sidx_reg];
            rss_reg  <= rss_arr_reg[sidx_reg];
            cnt_reg  <= cnt_arr_reg[sidx_reg];
            mn_reg   <= mn_arr_reg[sidx_reg];
            mx_reg   <= mx_arr_reg[sidx_reg];
            m_reg    <= m_arr_reg[sidx_reg];
            sig_reg  <= sig_arr_reg[sidx_reg];
            comp_reg <= comp_arr_reg[sidx_reg];
            addr_reg <= ADDR_W'(sidx_reg) * ADDR_W'(WINDOW_DEPTH)
                      + ADDR_W'(wp_arr_reg[sidx_reg]);
        end
        // deviation sum: rss + n*m*m - 2*m*rs
        if (cmd.dev1) begin
            dd_reg  <= DW'(abs_dev) * DW'(abs_dev);
            mm_reg  <= DW'(m_reg) * DW'(m_reg);
            mrs_reg <= SQ_W'(m_reg) * SQ_W'(rs_reg);
            tt_reg  <= TT_W'(thr_reg) * TT_W'(thr_reg);
        end
        if (cmd.dev2) begin
            nmm_reg <= SQ_W'(mm_reg) * SQ_W'(n_reg);
            lhs_reg <= SQ_W'(dd_reg) * SQ_W'(n_reg);
        end
        if (cmd.dev3) begin
            dsq_reg <= rss_reg + nmm_reg - (mrs_reg << 1);
        end
        // t^2 * deviation sum, split at bit 32
        if (cmd.rhs1) begin
            rlo_reg <= RLO_W'(tt_reg) * RLO_W'(dsq_reg[31:0]);
            rhi_reg <= RHI_W'(tt_reg) * RHI_W'(dsq_reg[SQ_W-1:32]);
        end
        if (cmd.rhs2) begin
            rhs_reg <= CMP_W'(rlo_reg) + (CMP_W'(rhi_reg) << 32);
        end
        if (cmd.sqr) begin
            old_reg <= old_eff;
            osq_reg <= DW'(old_eff) * DW'(old_eff);
            xsq_reg <= DW'(x_reg) * DW'(x_reg);
        end
        if (cmd.upd) begin
            rs_reg  <= rs_reg - SUM_W'(old_reg) + SUM_W'(x_reg);
            rss_reg <= rss_reg - SQ_W'(osq_reg) + SQ_W'(xsq_reg);
            if (!full) begin
                n_reg <= n_reg + 1'b1;
            end
            wp_reg <= (wp_reg == WP_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (cnt_reg != '1) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (x_reg < mn_reg) mn_reg <= x_reg;
            if (x_reg > mx_reg) mx_reg <= x_reg;
        end
        if (cmd.take_mean) begin
            m_reg <= div_q[L-1:0];
        end
        if (cmd.fin) begin
            sig_reg <= root[L-1:0];
            if (cnt_reg >= COUNT_W'(COMP_MIN_COUNT)) begin
                comp_reg <= (L+1)'(0) - {1'b0, m_reg};
            end
        end
    end

    wlt_div #(
        .DVD_W (SQ_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    wlt_sqrt #(
        .W (SQ_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .operand (div_q),
        .done    (sqrt_done),
        .root    (root)
    );

    // result word
    always_comb begin
        if (cmd.out_status == ST_DISABLED) begin
            out_data_next = OUT_W'({slot_reg, cmd.out_status});
        end else begin
            out_data_next = OUT_W'({cnt_reg, comp_reg, sig_reg, mx_reg, mn_reg,
                                    m_reg, slot_reg, cmd.out_status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign sts.enabled      = en_reg;
    assign sts.check_needed = oen_reg && (cnt_reg >= COUNT_W'(OUTLIER_MIN_COUNT))
                              && (n_reg != '0);
    assign sts.outlier      = (CMP_W'(lhs_reg) << 8) > rhs_reg;
    assign sts.div_done     = div_done;
    assign sts.sqrt_done    = sqrt_done;
    assign sts.out_busy     = out_valid_reg && !m_axis_tready;

endmodule
